// ===== rtl/core/amed_pkg.sv =====
// shared widths, register codes, reset values and types of the magnitude event detector
`default_nettype none

package amed_pkg;

  // sample width of each axis
  localparam int SAMPLE_BITS = 16;

  // sum of three squares and its square root
  localparam int SUM_W  = 2 * SAMPLE_BITS + 2;
  localparam int RT_W   = SAMPLE_BITS + 1;
  localparam int REM_W  = RT_W + 3;
  localparam int RT_CNT_W = $clog2(RT_W + 1);

  // register and product widths
  localparam int REG_W  = 16;
  localparam int PROD_W = 2 * REG_W;
  localparam int TIME_W = 32;

  // serial multiply runs long enough for both the squares and the fraction product
  localparam int MUL_STEPS = (SAMPLE_BITS > REG_W) ? SAMPLE_BITS : REG_W;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);

  // deviation width before saturation
  localparam int EXT_W = (RT_W > REG_W) ? RT_W : REG_W;
  localparam int DEV_W = EXT_W + 1;

  // stream widths, padded to whole bytes
  localparam int IN_DATA_W  = ((3 * SAMPLE_BITS + TIME_W + 7) / 8) * 8;
  localparam int OUT_FLD_W  = REG_W + 3;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  // configuration port
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_HOLD      = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_FRACTION  = CFG_IDX_W'(3);

  localparam logic [REG_W-1:0] GRAVITY_RST   = 16'd16384;
  localparam logic [REG_W-1:0] THRESHOLD_RST = 16'd1420;
  localparam logic [REG_W-1:0] HOLD_RST      = 16'd500;
  localparam logic [REG_W-1:0] FRACTION_RST  = 16'd3277;

  typedef struct packed {
    logic [REG_W-1:0] gravity_level;
    logic [REG_W-1:0] net_threshold;
    logic [REG_W-1:0] hold_time_ms;
    logic [REG_W-1:0] change_fraction;
  } amed_cfg_t;

  typedef struct packed {
    logic [REG_W-1:0] net_accel;
    logic             level_changed;
    logic             motion_active;
    logic             quake_detected;
  } amed_result_t;

  typedef struct packed {
    logic ld_net;
    logic commit;
  } amed_evt_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/amed_sqsum.sv =====
// bit-serial sum of squares of three axes and reference-times-fraction product
`default_nettype none

module amed_sqsum (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [amed_pkg::SAMPLE_BITS-1:0] accel_x,
  input  wire logic [amed_pkg::SAMPLE_BITS-1:0] accel_y,
  input  wire logic [amed_pkg::SAMPLE_BITS-1:0] accel_z,
  input  wire logic [amed_pkg::REG_W-1:0]       ref_level,
  input  wire logic [amed_pkg::REG_W-1:0]       fraction,
  output logic                                  done,
  output logic [amed_pkg::SUM_W-1:0]            sum,
  output logic [amed_pkg::PROD_W-1:0]           prod
);

  localparam int SB = amed_pkg::SAMPLE_BITS;
  localparam int SW = amed_pkg::SUM_W;
  localparam int RW = amed_pkg::REG_W;
  localparam int PW = amed_pkg::PROD_W;
  localparam int CW = amed_pkg::MUL_CNT_W;

  logic [SB-1:0] mx_r, my_r, mz_r;
  logic [SW-1:0] cx_r, cy_r, cz_r;
  logic [SW-1:0] acc_r, acc_nxt;
  logic [RW-1:0] pm_r;
  logic [PW-1:0] pc_r;
  logic [PW-1:0] pacc_r, pacc_nxt;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [SB-1:0] abs_x, abs_y, abs_z;

  // magnitude of each two's complement sample
  always_comb begin
    abs_x = accel_x[SB-1] ? (~accel_x + SB'(1)) : accel_x;
    abs_y = accel_y[SB-1] ? (~accel_y + SB'(1)) : accel_y;
    abs_z = accel_z[SB-1] ? (~accel_z + SB'(1)) : accel_z;
  end

  // one multiplier bit of each product per cycle
  always_comb begin
    acc_nxt = acc_r + (mx_r[0] ? cx_r : '0) + (my_r[0] ? cy_r : '0)
                    + (mz_r[0] ? cz_r : '0);
    pacc_nxt = pacc_r + (pm_r[0] ? pc_r : '0);
  end

  // control: iteration counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(amed_pkg::MUL_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift registers and accumulators
  always_ff @(posedge clk) begin
    if (start) begin
      mx_r   <= abs_x;
      my_r   <= abs_y;
      mz_r   <= abs_z;
      cx_r   <= SW'(abs_x);
      cy_r   <= SW'(abs_y);
      cz_r   <= SW'(abs_z);
      acc_r  <= '0;
      pm_r   <= fraction;
      pc_r   <= PW'(ref_level);
      pacc_r <= '0;
    end else if (busy_r) begin
      mx_r   <= mx_r >> 1;
      my_r   <= my_r >> 1;
      mz_r   <= mz_r >> 1;
      cx_r   <= cx_r << 1;
      cy_r   <= cy_r << 1;
      cz_r   <= cz_r << 1;
      acc_r  <= acc_nxt;
      pm_r   <= pm_r >> 1;
      pc_r   <= pc_r << 1;
      pacc_r <= pacc_nxt;
    end
  end

  assign done = done_r;
  assign sum  = acc_r;
  assign prod = pacc_r;

endmodule

`default_nettype wire

// ===== rtl/core/amed_isqrt.sv =====
// integer square root, one result bit per cycle
`default_nettype none

module amed_isqrt (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [amed_pkg::SUM_W-1:0] radicand,
  output logic                            done,
  output logic [amed_pkg::RT_W-1:0]       root
);

  localparam int SW = amed_pkg::SUM_W;
  localparam int TW = amed_pkg::RT_W;
  localparam int MW = amed_pkg::REM_W;
  localparam int CW = amed_pkg::RT_CNT_W;

  logic [SW-1:0] n_r;
  logic [MW-1:0] rem_r, rem_nxt;
  logic [TW-1:0] root_r, root_nxt;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [MW-1:0] rem_sh;
  logic [MW-1:0] trial;
  logic          fits;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    rem_sh   = {rem_r[MW-3:0], n_r[SW-1 -: 2]};
    trial    = MW'({root_r, 2'b01});
    fits     = (rem_sh >= trial);
    rem_nxt  = fits ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_r[TW-2:0], fits};
  end

  // control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(TW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      n_r    <= n_r << 2;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

// ===== rtl/core/amed_event.sv =====
// deviation from one g, change band, activity timing and detector state
`default_nettype none

module amed_event (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire amed_pkg::amed_evt_ctrl_t     ctrl,
  input  wire amed_pkg::amed_cfg_t          cfg,
  input  wire logic [amed_pkg::RT_W-1:0]    root,
  input  wire logic [amed_pkg::PROD_W-1:0]  prod,
  input  wire logic [amed_pkg::TIME_W-1:0]  time_ms,
  output logic [amed_pkg::REG_W-1:0]        ref_level,
  output amed_pkg::amed_result_t            res
);

  localparam int RW = amed_pkg::REG_W;
  localparam int XW = amed_pkg::EXT_W;
  localparam int DW = amed_pkg::DEV_W;
  localparam int TW = amed_pkg::TIME_W;

  logic [RW-1:0] net_r;
  logic [RW-1:0] ref_level_r;
  logic [TW-1:0] onset_r;
  logic          active_r;

  logic [XW-1:0] root_x, grav_x, dev;
  logic [DW-1:0] dev_x;
  logic [RW-1:0] net_nxt;
  logic [RW-1:0] diff;
  logic          changed, moving, quake;
  logic [TW-1:0] elapsed;

  // saturated absolute deviation of the magnitude
  always_comb begin
    root_x  = XW'(root);
    grav_x  = XW'(cfg.gravity_level);
    dev     = (root_x >= grav_x) ? (root_x - grav_x) : (grav_x - root_x);
    dev_x   = DW'(dev);
    net_nxt = (|dev_x[DW-1:RW]) ? {RW{1'b1}} : dev_x[RW-1:0];
  end

  // change band, threshold and hold time
  always_comb begin
    diff    = (net_r >= ref_level_r) ? (net_r - ref_level_r) : (ref_level_r - net_r);
    changed = ({diff, {RW{1'b0}}} > prod);
    moving  = (net_r > cfg.net_threshold);
    elapsed = time_ms - onset_r;
    quake   = moving && active_r && (elapsed > TW'(cfg.hold_time_ms));
    res.net_accel      = net_r;
    res.level_changed  = changed;
    res.motion_active  = moving;
    res.quake_detected = quake;
  end

  // deviation register
  always_ff @(posedge clk) begin
    if (ctrl.ld_net) begin
      net_r <= net_nxt;
    end
  end

  // detector state, updated as the result is handed out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_level_r <= '0;
      onset_r     <= '0;
      active_r    <= 1'b0;
    end else if (ctrl.commit) begin
      if (changed) begin
        ref_level_r <= net_r;
      end
      if (moving) begin
        if (!active_r) begin
          active_r <= 1'b1;
          onset_r  <= time_ms;
        end
      end else begin
        active_r <= 1'b0;
        onset_r  <= '0;
      end
    end
  end

  // stored reference level feeds the fraction product of the next sample
  assign ref_level = ref_level_r;

endmodule

`default_nettype wire

// ===== rtl/core/accel_magnitude_event_detector_core.sv =====
// top level of the accelerometer magnitude event detector
`default_nettype none

// Takes one three-axis sample with a millisecond timestamp per request and returns one
// result: the saturated deviation of the vector magnitude from the one-g level, a flag
// for a move beyond the relative change band, a flag for deviation above the threshold,
// and a flag for motion held longer than the hold time. One sample is processed at a
// time: a bit-serial squarer forms the sum of squares, then the square root produces
// one bit per cycle, then the deviation is registered and the flags are formed and
// committed to the output register once that register is free. A finished result
// waits in the output register while the next sample is taken in. Configuration
// writes are always ready and must only be made while the block is idle; writes to
// an index beyond the four registers are dropped.
module accel_magnitude_event_detector_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // accel_x, accel_y, accel_z, time_ms, from bit 0 up; zero padding above
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [amed_pkg::IN_DATA_W-1:0]     in_tdata,
  // net_accel, level_changed, motion_active, quake_detected, from bit 0 up; zero padding
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [amed_pkg::OUT_DATA_W-1:0]         out_tdata,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [amed_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [amed_pkg::REG_W-1:0]         cfg_data
);

  localparam int SB = amed_pkg::SAMPLE_BITS;
  localparam int TW = amed_pkg::TIME_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_FLAG = 3'd3;

  logic [2:0]                    state_r, state_nxt;
  amed_pkg::amed_cfg_t           cfg_r;
  logic [TW-1:0]                 time_r;
  amed_pkg::amed_result_t        out_r;
  logic                          out_valid_r;
  amed_pkg::amed_result_t        res;
  amed_pkg::amed_evt_ctrl_t      ctrl;
  logic                          in_fire;
  logic                          sq_done, rt_done;
  logic [amed_pkg::SUM_W-1:0]    sq_sum;
  logic [amed_pkg::PROD_W-1:0]   sq_prod;
  logic [amed_pkg::RT_W-1:0]     rt_root;
  logic [amed_pkg::REG_W-1:0]    ev_ref_level;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gravity_level   <= amed_pkg::GRAVITY_RST;
      cfg_r.net_threshold   <= amed_pkg::THRESHOLD_RST;
      cfg_r.hold_time_ms    <= amed_pkg::HOLD_RST;
      cfg_r.change_fraction <= amed_pkg::FRACTION_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        amed_pkg::REG_GRAVITY:   cfg_r.gravity_level   <= cfg_data;
        amed_pkg::REG_THRESHOLD: cfg_r.net_threshold   <= cfg_data;
        amed_pkg::REG_HOLD:      cfg_r.hold_time_ms    <= cfg_data;
        amed_pkg::REG_FRACTION:  cfg_r.change_fraction <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    ctrl.ld_net = 1'b0;
    ctrl.commit = 1'b0;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_MUL;
      S_MUL:  if (sq_done) state_nxt = S_SQRT;
      S_SQRT: begin
        if (rt_done) begin
          ctrl.ld_net = 1'b1;
          state_nxt   = S_FLAG;
        end
      end
      S_FLAG: begin
        if (!out_valid_r || out_tready) begin
          ctrl.commit = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // timestamp of the sample in flight
  always_ff @(posedge clk) begin
    if (in_fire) begin
      time_r <= in_tdata[3*SB +: TW];
    end
  end

  amed_sqsum u_sqsum (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_fire),
    .accel_x   (in_tdata[0 +: SB]),
    .accel_y   (in_tdata[SB +: SB]),
    .accel_z   (in_tdata[2*SB +: SB]),
    .ref_level (ev_ref_level),
    .fraction  (cfg_r.change_fraction),
    .done      (sq_done),
    .sum       (sq_sum),
    .prod      (sq_prod)
  );

  amed_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_done),
    .radicand (sq_sum),
    .done     (rt_done),
    .root     (rt_root)
  );

  amed_event u_event (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .cfg       (cfg_r),
    .root      (rt_root),
    .prod      (sq_prod),
    .time_ms   (time_r),
    .ref_level (ev_ref_level),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = amed_pkg::OUT_DATA_W'({out_r.quake_detected, out_r.motion_active,
                                             out_r.level_changed, out_r.net_accel});

`ifndef NO_ASSERTIONS
  a_sq_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> (state_r == S_MUL))
    else $error("square sum finished outside the multiply phase");

  a_rt_done_in_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
    rt_done |-> (state_r == S_SQRT))
    else $error("square root finished outside the root phase");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_MUL))
    else $error("accepted request did not start the multiply phase");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.commit |=> out_tvalid)
    else $error("committed result not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.commit |-> (!out_valid_r || out_tready))
    else $error("result register overwritten while still pending");
`endif

endmodule

`default_nettype wire

// ===== test/amed_checker.sv =====
// checker for the magnitude event detector: watches all three channels, predicts and compares
`default_nettype none

module amed_checker
  import amed_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [OUT_DATA_W-1:0] out_tdata,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [REG_W-1:0]      cfg_data,
  output int                         fail_cnt,
  output int                         accepted_cnt,
  output int                         checked_cnt,
  output int                         change_cnt,
  output int                         motion_cnt,
  output int                         quake_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copy and detector state as the block should hold them
  amed_cfg_t         settings;
  logic [REG_W-1:0]  ref_level;
  logic [TIME_W-1:0] onset_ms;
  logic              tracking;

  // results still owed by the block, oldest first
  amed_result_t owed_results[$];

  // largest r with r*r <= n, found one bit at a time from the top
  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = SAMPLE_BITS + 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // result of one sample request; advances the reference level and the motion timer
  function automatic amed_result_t next_result(input logic [IN_DATA_W-1:0] req);
    logic signed [SAMPLE_BITS-1:0] ax;
    logic signed [SAMPLE_BITS-1:0] ay;
    logic signed [SAMPLE_BITS-1:0] az;
    logic [TIME_W-1:0]             now;
    longint                        sum;
    longint                        dev;
    logic [REG_W-1:0]              net;
    logic [REG_W-1:0]              gap;
    amed_result_t                  r;
    ax  = req[SAMPLE_BITS-1:0];
    ay  = req[2*SAMPLE_BITS-1:SAMPLE_BITS];
    az  = req[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
    now = req[3*SAMPLE_BITS+TIME_W-1:3*SAMPLE_BITS];
    sum = longint'(ax) * longint'(ax) + longint'(ay) * longint'(ay)
        + longint'(az) * longint'(az);
    dev = longint'(floor_sqrt(unsigned'(sum))) - longint'(settings.gravity_level);
    if (dev < 0) dev = -dev;
    net = (dev > 65535) ? '1 : dev[REG_W-1:0];
    gap = (net >= ref_level) ? net - ref_level : ref_level - net;
    r.net_accel     = net;
    r.level_changed = {gap, 16'h0000} > 32'(ref_level) * 32'(settings.change_fraction);
    r.motion_active = net > settings.net_threshold;
    if (r.level_changed) ref_level = net;
    // onset is latched on the first active sample and cleared when motion stops
    if (!r.motion_active) begin
      tracking = 1'b0;
      onset_ms = '0;
    end else if (!tracking) begin
      tracking = 1'b1;
      onset_ms = now;
    end
    r.quake_detected = tracking && ((now - onset_ms) > TIME_W'(settings.hold_time_ms));
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("[%0t] result %0d: %s is %0d, expected %0d", $time, checked_cnt, what, got,
             want);
    fail_cnt++;
  endtask

  always @(posedge clk) begin : watch
    amed_result_t             want;
    logic [OUT_DATA_W-1:0]    got;
    if (!rst_n) begin
      settings = '{GRAVITY_RST, THRESHOLD_RST, HOLD_RST, FRACTION_RST};
      ref_level = '0;
      onset_ms  = '0;
      tracking  = 1'b0;
      owed_results.delete();
      fail_cnt = 0;
      accepted_cnt <= 0;
      checked_cnt  <= 0;
      change_cnt   <= 0;
      motion_cnt   <= 0;
      quake_cnt    <= 0;
    end else begin
      // register write, indexes past the last register change nothing
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRAVITY:   settings.gravity_level   = cfg_data;
          REG_THRESHOLD: settings.net_threshold   = cfg_data;
          REG_HOLD:      settings.hold_time_ms    = cfg_data;
          REG_FRACTION:  settings.change_fraction = cfg_data;
          default: ;
        endcase
      end
      // sample request
      if (in_tvalid && in_tready) begin
        owed_results.push_back(next_result(in_tdata));
        accepted_cnt <= accepted_cnt + 1;
      end
      // result request: net_accel [15:0], level_changed [16], motion_active [17],
      // quake_detected [18], zero padding above
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (owed_results.size() == 0) begin
          report_mismatch("result with no sample pending, net_accel", got[REG_W-1:0], 0);
        end else begin
          want = owed_results.pop_front();
          if (got[REG_W-1:0] != want.net_accel)
            report_mismatch("net_accel", got[REG_W-1:0], want.net_accel);
          if (got[REG_W] != want.level_changed)
            report_mismatch("level_changed", got[REG_W], want.level_changed);
          if (got[REG_W+1] != want.motion_active)
            report_mismatch("motion_active", got[REG_W+1], want.motion_active);
          if (got[REG_W+2] != want.quake_detected)
            report_mismatch("quake_detected", got[REG_W+2], want.quake_detected);
          if (got[OUT_DATA_W-1:OUT_FLD_W] != '0)
            report_mismatch("padding", got[OUT_DATA_W-1:OUT_FLD_W], 0);
          checked_cnt <= checked_cnt + 1;
          change_cnt  <= change_cnt + int'(want.level_changed);
          motion_cnt  <= motion_cnt + int'(want.motion_active);
          quake_cnt   <= quake_cnt + int'(want.quake_detected);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// testbench top: sample stimulus, idling, register settings and verdict for the detector
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import amed_pkg::*;

  localparam int RANDOM_PER_SETTING = 130;
  localparam int SETTLE_CYCLES      = 60;
  localparam logic [CFG_IDX_W-1:0] NO_SUCH_REG   = '1;
  localparam logic [CFG_IDX_W-1:0] PAST_LAST_REG = REG_FRACTION + 1'b1;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata  = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [REG_W-1:0]      cfg_data  = '0;

  int fail_cnt;
  int accepted_cnt;
  int checked_cnt;
  int change_cnt;
  int motion_cnt;
  int quake_cnt;

  // idling rates in percent; the receiver rate is only changed with nonblocking writes
  int send_idle_pct  = 11;
  int recv_stall_pct = 70;
  int sample_cnt     = 0;

  // settings as last written, used to aim samples around gravity and threshold
  logic [REG_W-1:0]  aim_gravity   = GRAVITY_RST;
  logic [REG_W-1:0]  aim_threshold = THRESHOLD_RST;
  logic [REG_W-1:0]  aim_hold      = HOLD_RST;
  logic [TIME_W-1:0] now_ms        = '0;

  accel_magnitude_event_detector_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  amed_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_cnt     (fail_cnt),
    .accepted_cnt (accepted_cnt),
    .checked_cnt  (checked_cnt),
    .change_cnt   (change_cnt),
    .motion_cnt   (motion_cnt),
    .quake_cnt    (quake_cnt)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // run limit
  initial begin
    #4_000_000;
    $display("timeout with %0d results still owed", accepted_cnt - checked_cnt);
    $display("*** FAILED ***");
    $finish;
  end

  // one sample request; in_tdata is accel_x, accel_y, accel_z, time_ms from bit 0 up
  task automatic drive_sample(input logic signed [15:0] ax, input logic signed [15:0] ay,
                              input logic signed [15:0] az, input logic [TIME_W-1:0] t);
    // idling pattern moves on after each third of the run
    if (sample_cnt == 225) begin
      send_idle_pct = 70;
      recv_stall_pct <= 11;
    end else if (sample_cnt == 450) begin
      send_idle_pct = 0;
      recv_stall_pct <= 0;
    end
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 45)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {t, az, ay, ax};
    do @(posedge clk); while (!in_tready);
    sample_cnt++;
  endtask

  // hold off the sender until every owed result has come back
  task automatic wait_results;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (accepted_cnt != checked_cnt);
  endtask

  // register write request; cfg_valid is left high for back-to-back writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GRAVITY:   aim_gravity   = val;
      REG_THRESHOLD: aim_threshold = val;
      REG_HOLD:      aim_hold      = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [REG_W-1:0] grav, input logic [REG_W-1:0] thr,
                               input logic [REG_W-1:0] hold, input logic [REG_W-1:0] frac);
    wait_results;
    write_reg(REG_GRAVITY, grav);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_HOLD, hold);
    write_reg(REG_FRACTION, frac);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic               burst;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    longint             goal;
    longint             swing;
    int                 pick;

    burst = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: exact one g, all-zero and full-scale samples, onset at time zero
    drive_sample(16'sd0, 16'sd0, 16'sd16384, 32'd0);
    drive_sample(16'sd0, 16'sd0, 16'sd0, 32'd0);
    drive_sample(16'sh8000, 16'sh8000, 16'sh8000, 32'd600);
    drive_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'd601);
    drive_sample(16'sh8000, 16'sd0, 16'sd0, 32'd700);
    // motion ends
    drive_sample(16'sd0, 16'sd16384, 16'sd0, 32'd701);
    // threshold edge: 1420 counts is quiet, 1421 is motion
    drive_sample(16'sd0, 16'sd0, 16'sd17804, 32'd702);
    drive_sample(16'sd0, -16'sd17805, 16'sd0, 32'd703);
    drive_sample(16'sd0, 16'sd0, 16'sd16384, 32'd704);
    // hold time running out across the timestamp wrap
    drive_sample(16'sd0, 16'sd0, 16'sd20000, 32'hFFFF_FFF0);
    drive_sample(16'sd0, 16'sd0, 16'sd20010, 32'hFFFF_FFFF);
    drive_sample(16'sd0, 16'sd0, -16'sd20000, 32'h0000_0200);
    drive_sample(16'sd1, -16'sd1, 16'sd16384, 32'h0000_0201);

    // zero hold and zero change band; writes past the last register must change nothing
    wait_results;
    write_reg(REG_HOLD, 16'd0);
    write_reg(REG_FRACTION, 16'd0);
    write_reg(NO_SUCH_REG, 16'hFFFF);
    write_reg(PAST_LAST_REG, 16'd0);
    cfg_valid <= 1'b0;
    drive_sample(16'sd0, 16'sd0, 16'sd16384, 32'd50);
    // zero reference, one count of deviation is a change
    drive_sample(16'sd0, 16'sd0, 16'sd16385, 32'd51);
    // onset sample never detects, same timestamp neither, one millisecond later does
    drive_sample(16'sd0, 16'sd0, 16'sd20000, 32'd1000);
    drive_sample(16'sd0, 16'sd0, 16'sd20000, 32'd1000);
    drive_sample(16'sd0, 16'sd0, 16'sd20001, 32'd1001);
    drive_sample(16'sd0, 16'sd0, 16'sd16384, 32'd1002);

    // random part: defaults, all zero, full scale, then two random settings
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: apply_setting(GRAVITY_RST, THRESHOLD_RST, HOLD_RST, FRACTION_RST);
        1: apply_setting(16'd0, 16'd0, 16'd0, 16'd0);
        2: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: apply_setting(REG_W'($urandom_range(12000, 20000)), REG_W'($urandom_range(0, 3000)),
                         REG_W'($urandom_range(0, 400)), REG_W'($urandom));
        default: apply_setting(REG_W'($urandom), REG_W'($urandom_range(0, 20000)),
                               REG_W'($urandom_range(0, 1000)), REG_W'($urandom));
      endcase
      for (int k = 0; k < RANDOM_PER_SETTING; k++) begin
        // bursts of motion come and go so that the hold timer gets to run out
        if (burst) burst = ($urandom_range(99) >= 6);
        else       burst = ($urandom_range(99) < 9);
        pick = $urandom_range(99);
        if (pick < 8) begin
          ax = 16'($urandom);
          ay = 16'($urandom);
          az = 16'($urandom);
        end else begin
          if (burst) begin
            swing = longint'($urandom_range(0, 2 * aim_threshold + 400));
            ax = 16'($urandom_range(0, 4000) - 2000);
            ay = 16'($urandom_range(0, 4000) - 2000);
          end else begin
            swing = longint'($urandom_range(0, aim_threshold / 2 + 50));
            ax = 16'($urandom_range(0, 600) - 300);
            ay = 16'($urandom_range(0, 600) - 300);
          end
          goal = longint'(aim_gravity) + ($urandom_range(1) ? swing : -swing);
          if ($urandom_range(1)) goal = -goal;
          if (goal > 32767) goal = 32767;
          else if (goal < -32768) goal = -32768;
          az = goal[15:0];
        end
        // mostly small forward steps, sometimes long ones, now and then a jump anywhere
        pick = $urandom_range(99);
        if (pick < 80)      now_ms += $urandom_range(0, 30);
        else if (pick < 96) now_ms += $urandom_range(0, 2 * aim_hold + 10);
        else                now_ms = $urandom;
        drive_sample(ax, ay, az, now_ms);
        if ($urandom_range(99) < 2) wait_results;
      end
    end

    wait_results;
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d samples and %0d compared results over seven register settings",
             sample_cnt, checked_cnt);
    $display("results with motion %0d, with level change %0d, with detection %0d",
             motion_cnt, change_cnt, quake_cnt);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
